// File: hw/rtl/rc4x_pkg.sv
// ----------------------------------------------------------------------------
// rc4x_pkg
// Shared types and constants for the RC4 stream cipher with extra XOR byte.
// ----------------------------------------------------------------------------
package rc4x_pkg;

  localparam int BYTE_W            = 8;
  localparam int PERM_DEPTH        = 256;
  localparam int PERM_AW           = $clog2(PERM_DEPTH);
  localparam int KEY_W             = 64;
  localparam int LEN_W             = 5;
  localparam int CFG_DATA_W        = 64;
  localparam int CFG_IDX_W         = 2;
  localparam int MAX_KEY_BYTES_DEF = 16;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_LOW  = 2'd0,
    REG_KEY_HIGH = 2'd1,
    REG_KEY_LEN  = 2'd2,
    REG_EXTRA    = 2'd3
  } cfg_reg_t;

  // Input kind codes.
  localparam logic KIND_REKEY = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DATA_J,
    ST_DATA_K,
    ST_DATA_FIN,
    ST_KEY_RD,
    ST_KEY_WR_N,
    ST_KEY_WR_A
  } state_t;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_DATA_START,
    OP_DATA_J,
    OP_DATA_K,
    OP_DATA_FIN,
    OP_KEY_START,
    OP_KEY_RD,
    OP_KEY_WR_N,
    OP_KEY_WR_A
  } op_t;

  typedef struct packed {
    logic n_last;    // key schedule is on its final entry
    logic out_busy;  // result register holds a beat that is not taken this cycle
  } status_t;

endpackage

// File: hw/rtl/rc4x_ctrl.sv
// ----------------------------------------------------------------------------
// rc4x_ctrl
// Sequencer for data bytes and the key schedule; issues one datapath
// operation per cycle.
// ----------------------------------------------------------------------------
module rc4x_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               kind,
  output logic               in_stall,
  input  rc4x_pkg::status_t  status,
  output rc4x_pkg::op_t      op
);

  rc4x_pkg::state_t state;
  rc4x_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rc4x_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = rc4x_pkg::OP_NONE;
    in_stall   = (state != rc4x_pkg::ST_IDLE);
    unique case (state)
      rc4x_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (kind == rc4x_pkg::KIND_DATA) begin
            op         = rc4x_pkg::OP_DATA_START;
            state_next = rc4x_pkg::ST_DATA_J;
          end else begin
            op         = rc4x_pkg::OP_KEY_START;
            state_next = rc4x_pkg::ST_KEY_RD;
          end
        end
      end
      rc4x_pkg::ST_DATA_J: begin
        op         = rc4x_pkg::OP_DATA_J;
        state_next = rc4x_pkg::ST_DATA_K;
      end
      rc4x_pkg::ST_DATA_K: begin
        op         = rc4x_pkg::OP_DATA_K;
        state_next = rc4x_pkg::ST_DATA_FIN;
      end
      rc4x_pkg::ST_DATA_FIN: begin
        // The result register must be free before the swap is finished.
        if (!status.out_busy) begin
          op         = rc4x_pkg::OP_DATA_FIN;
          state_next = rc4x_pkg::ST_IDLE;
        end
      end
      rc4x_pkg::ST_KEY_RD: begin
        op         = rc4x_pkg::OP_KEY_RD;
        state_next = rc4x_pkg::ST_KEY_WR_N;
      end
      rc4x_pkg::ST_KEY_WR_N: begin
        op         = rc4x_pkg::OP_KEY_WR_N;
        state_next = rc4x_pkg::ST_KEY_WR_A;
      end
      rc4x_pkg::ST_KEY_WR_A: begin
        op         = rc4x_pkg::OP_KEY_WR_A;
        state_next = status.n_last ? rc4x_pkg::ST_IDLE : rc4x_pkg::ST_KEY_RD;
      end
      default: begin
        state_next = rc4x_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/rc4x_datapath.sv
// ----------------------------------------------------------------------------
// rc4x_datapath
// Permutation table, indexes, key registers and the result register.
// ----------------------------------------------------------------------------
module rc4x_datapath #(
  parameter int MAX_KEY_BYTES = rc4x_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  rc4x_pkg::op_t                   op,
  output rc4x_pkg::status_t               status,
  input  logic [rc4x_pkg::BYTE_W-1:0]     data_byte,
  input  logic                            cfg_write,
  input  logic [rc4x_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rc4x_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rc4x_pkg::BYTE_W-1:0]     out_byte
);

  localparam int BW     = rc4x_pkg::BYTE_W;
  localparam int AW     = rc4x_pkg::PERM_AW;
  localparam int DEPTH  = rc4x_pkg::PERM_DEPTH;
  localparam int LW     = rc4x_pkg::LEN_W;
  localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  // Configuration registers.
  logic [rc4x_pkg::KEY_W-1:0] key_low;
  logic [rc4x_pkg::KEY_W-1:0] key_high;
  logic [LW-1:0]              key_len;
  logic [BW-1:0]              extra;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
      key_len  <= LW'(1);
      extra    <= '0;
    end else if (cfg_write) begin
      unique case (rc4x_pkg::cfg_reg_t'(cfg_index))
        rc4x_pkg::REG_KEY_LOW:  key_low  <= cfg_data;
        rc4x_pkg::REG_KEY_HIGH: key_high <= cfg_data;
        rc4x_pkg::REG_KEY_LEN:  key_len  <= cfg_data[LW-1:0];
        rc4x_pkg::REG_EXTRA:    extra    <= cfg_data[BW-1:0];
        default: ;
      endcase
    end
  end

  // Permutation table: one write and one registered read per cycle.
  // An entry whose valid bit is clear reads as its own address (identity).
  logic [BW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [BW-1:0]    mem_q;
  logic             vld_q;
  logic [AW-1:0]    addr_q;
  logic             fwd_q;

  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [BW-1:0] wr_data;
  logic [BW-1:0] rv;

  // Working registers.
  logic [AW-1:0]     idx_i;
  logic [AW-1:0]     idx_j;
  logic [BW-1:0]     a_val;
  logic [BW-1:0]     b_val;
  logic [AW-1:0]     t_val;
  logic [BW-1:0]     din;
  logic [BW-1:0]     sn;
  logic [AW-1:0]     acc;
  logic [AW-1:0]     n;
  logic [KIDX_W-1:0] key_idx;

  logic [AW-1:0]  i_inc;
  logic [AW-1:0]  j_new;
  logic [AW-1:0]  t_new;
  logic [AW-1:0]  acc_new;
  logic [AW-1:0]  n_inc;
  logic [BW-1:0]  ks;
  logic [BW-1:0]  key_byte;
  logic [3:0]     key_pos;
  logic [2*rc4x_pkg::KEY_W-1:0] key_all;
  logic [LW-1:0]  len_eff;
  logic           key_wrap;

  // A forwarded read covers the key schedule case where the next entry
  // is the one written in the same cycle.
  assign rv = fwd_q ? sn : (vld_q ? mem_q : BW'(addr_q));

  assign i_inc   = idx_i + AW'(1);
  assign j_new   = idx_j + AW'(rv);
  assign t_new   = AW'(a_val) + AW'(rv);
  assign n_inc   = n + AW'(1);
  assign key_all = {key_high, key_low};
  assign key_pos = 4'(key_idx);
  assign key_byte = key_all[{key_pos, 3'b000} +: BW];
  assign acc_new = acc + AW'(rv) + AW'(key_byte);

  always_comb begin
    if (key_len == '0) begin
      len_eff = LW'(1);
    end else if (key_len > LW'(MAX_KEY_BYTES)) begin
      len_eff = LW'(MAX_KEY_BYTES);
    end else begin
      len_eff = key_len;
    end
  end

  assign key_wrap = (LW'(key_idx) == (len_eff - LW'(1)));

  // After the swap, entry t is b when t is i, a when t is j, else as read.
  always_comb begin
    if (t_val == idx_i) begin
      ks = b_val;
    end else if (t_val == idx_j) begin
      ks = a_val;
    end else begin
      ks = rv;
    end
  end

  always_comb begin
    rd_addr = addr_q;
    wr_en   = 1'b0;
    wr_addr = idx_i;
    wr_data = rv;
    unique case (op)
      rc4x_pkg::OP_DATA_START: rd_addr = i_inc;
      rc4x_pkg::OP_DATA_J:     rd_addr = j_new;
      rc4x_pkg::OP_DATA_K: begin
        rd_addr = t_new;
        wr_en   = 1'b1;
        wr_addr = idx_i;
        wr_data = rv;
      end
      rc4x_pkg::OP_DATA_FIN: begin
        wr_en   = 1'b1;
        wr_addr = idx_j;
        wr_data = a_val;
      end
      rc4x_pkg::OP_KEY_START: rd_addr = '0;
      rc4x_pkg::OP_KEY_RD:    rd_addr = acc_new;
      rc4x_pkg::OP_KEY_WR_N: begin
        wr_en   = 1'b1;
        wr_addr = n;
        wr_data = rv;
      end
      rc4x_pkg::OP_KEY_WR_A: begin
        rd_addr = n_inc;
        wr_en   = 1'b1;
        wr_addr = acc;
        wr_data = sn;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q  <= mem[rd_addr];
    addr_q <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst || op == rc4x_pkg::OP_KEY_START) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= 1'b0;
      fwd_q <= 1'b0;
    end else begin
      vld_q <= (op == rc4x_pkg::OP_KEY_START) ? 1'b0 : vld[rd_addr];
      fwd_q <= (op == rc4x_pkg::OP_KEY_WR_A) && (n_inc == acc);
    end
  end

  // Indexes i and j are architectural state and reset to zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx_i <= '0;
      idx_j <= '0;
    end else begin
      unique case (op)
        rc4x_pkg::OP_DATA_START: idx_i <= i_inc;
        rc4x_pkg::OP_DATA_J:     idx_j <= j_new;
        rc4x_pkg::OP_KEY_WR_A: begin
          if (status.n_last) begin
            idx_i <= '0;
            idx_j <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      rc4x_pkg::OP_DATA_START: din <= data_byte;
      rc4x_pkg::OP_DATA_J:     a_val <= rv;
      rc4x_pkg::OP_DATA_K: begin
        b_val <= rv;
        t_val <= t_new;
      end
      rc4x_pkg::OP_KEY_START: begin
        n       <= '0;
        acc     <= '0;
        key_idx <= '0;
      end
      rc4x_pkg::OP_KEY_RD: begin
        sn  <= rv;
        acc <= acc_new;
      end
      rc4x_pkg::OP_KEY_WR_A: begin
        n       <= n_inc;
        key_idx <= key_wrap ? '0 : key_idx + KIDX_W'(1);
      end
      default: ;
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == rc4x_pkg::OP_DATA_FIN) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == rc4x_pkg::OP_DATA_FIN) begin
      out_byte <= din ^ ks ^ extra;
    end
  end

  assign status.n_last   = (n == AW'(DEPTH - 1));
  assign status.out_busy = out_valid && out_stall;

endmodule

// File: hw/rtl/rc4_stream_cipher_extra_xor_core.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher_extra_xor_core
// RC4 cipher core whose keystream byte is XORed with a configurable byte.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake           Payload
//  in       sink       in_valid/in_stall   kind, data_byte
//  out      source     out_valid/out_stall out_byte
//  cfg      sink       cfg_write           cfg_index, cfg_data
//
// A data byte runs through DATA_J, DATA_K and DATA_FIN before its result is
// registered; its three table reads (s[i], s[j], s[s[i]+s[j]]) are dependent.
// A rekey item starts with one read, then runs KEY_RD, KEY_WR_N and KEY_WR_A
// for each of the 256 key schedule steps. It gives no result beat.
// Reset and rekey restore the identity table at once through per-entry valid
// bits; there is no clearing pass. A new item is accepted while a result beat
// waits; a data byte holds in its last cycle until the result register frees.
module rc4_stream_cipher_extra_xor_core #(
  parameter int MAX_KEY_BYTES = rc4x_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            kind,
  input  logic [rc4x_pkg::BYTE_W-1:0]     data_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rc4x_pkg::BYTE_W-1:0]     out_byte,
  input  logic                            cfg_write,
  input  logic [rc4x_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rc4x_pkg::CFG_DATA_W-1:0] cfg_data
);

  rc4x_pkg::op_t     op;
  rc4x_pkg::status_t status;

  rc4x_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_stall (in_stall),
    .status   (status),
    .op       (op)
  );

  rc4x_datapath #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .status    (status),
    .data_byte (data_byte),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte)
  );

endmodule

// File: hw/rtl/rc4x_checker.sv
// ----------------------------------------------------------------------------
// rc4x_checker
// Port-level checks for the RC4 core, attached by bind.
// ----------------------------------------------------------------------------
module rc4x_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        kind,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [rc4x_pkg::BYTE_W-1:0] out_byte
);

  // A held result beat keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte))
    else $error("result beat changed while stalled");

  // A data byte keeps in_stall high while it works through its table states.
  a_data_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && kind == rc4x_pkg::KIND_DATA
    |=> in_stall ##1 in_stall ##1 in_stall)
    else $error("core took an item during a data byte");

  // A rekey beat produces no result beat right after it is accepted.
  a_rekey_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && kind == rc4x_pkg::KIND_REKEY
    |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result beat after rekey");

  // A result beat only appears at the end of work in progress.
  a_out_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result beat without an item in progress");

endmodule

bind rc4_stream_cipher_extra_xor_core rc4x_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .kind      (kind),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte)
);
